[src/scf_pkg.sv]
// ---------------------------------------------------------------------------
// scf_pkg
// Shared types and constants of the script flow sequencer.
// ---------------------------------------------------------------------------
package scf_pkg;

   // Return stack depth default
   localparam int DEFAULT_STACK_DEPTH = 16;

   // Field widths
   localparam int CLUSTER_W = 16;
   localparam int OFFSET_W  = 12;
   localparam int ENTRY_W   = CLUSTER_W + OFFSET_W;

   // Reset value of the slot present mask
   localparam logic [7:0] SLOT_MASK_RESET = 8'd27;

   // Cluster code that keeps the current cluster
   localparam logic [CLUSTER_W-1:0] KEEP_CLUSTER = 16'hFFFF;

   // Offset steps
   localparam logic [OFFSET_W-1:0] UNIT_STEP = 12'd8;
   localparam logic [OFFSET_W-1:0] CMD_STEP  = 12'd4;

   // Interpreter opcodes (bits 6..4 of the opcode byte)
   localparam logic [2:0] OP_IF     = 3'd1;
   localparam logic [2:0] OP_GOTO   = 3'd2;
   localparam logic [2:0] OP_CALL   = 3'd3;
   localparam logic [2:0] OP_RETURN = 3'd4;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_UNIT   = 3'd1,
      ST_UNIT_ERR  = 3'd2,
      ST_BAD_OP    = 3'd3,
      ST_OVERFLOW  = 3'd4,
      ST_UNDERFLOW = 3'd5
   } status_type;

   // Stack control from the sequencer
   typedef struct packed {
      logic               push;
      logic               pop;
      logic [ENTRY_W-1:0] data;
   } stack_ctl_type;

   // Stack status to the sequencer
   typedef struct packed {
      logic               full;
      logic               empty;
      logic [ENTRY_W-1:0] tos;
   } stack_stat_type;

   // One result item
   typedef struct packed {
      status_type           status;
      logic                 dispatch;
      logic [2:0]           unit_slot;
      logic [CLUSTER_W-1:0] cluster_now;
      logic [OFFSET_W-1:0]  offset_now;
      logic                 cluster_load;
   } rsp_type;

endpackage

[src/scf_req_if.sv]
// ---------------------------------------------------------------------------
// scf_req_if
// Request channel: one fetched command with its coprocessor result.
// ---------------------------------------------------------------------------
interface scf_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] cluster_field;
   logic [7:0]  offset_low_byte;
   logic [7:0]  opcode_byte;
   logic        unit_ok;
   logic        unit_result_zero;

   modport source (
      output valid, cluster_field, offset_low_byte, opcode_byte, unit_ok, unit_result_zero,
      input  ready
   );
   modport sink (
      input  valid, cluster_field, offset_low_byte, opcode_byte, unit_ok, unit_result_zero,
      output ready
   );
endinterface

[src/scf_rsp_if.sv]
// ---------------------------------------------------------------------------
// scf_rsp_if
// Response channel: sequencer status and position after one command.
// ---------------------------------------------------------------------------
interface scf_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        dispatch;
   logic [2:0]  unit_slot;
   logic [15:0] cluster_now;
   logic [11:0] offset_now;
   logic        cluster_load;

   modport source (
      output valid, status, dispatch, unit_slot, cluster_now, offset_now, cluster_load,
      input  ready
   );
   modport sink (
      input  valid, status, dispatch, unit_slot, cluster_now, offset_now, cluster_load,
      output ready
   );
endinterface

[src/scf_stack.sv]
// ---------------------------------------------------------------------------
// scf_stack
// Return stack. The top entry and the one below it sit in registers; deeper
// entries live in a memory, read into the second on pops at depth 3 or more.
// ---------------------------------------------------------------------------
module scf_stack #(
   parameter int STACK_DEPTH = scf_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  scf_pkg::stack_ctl_type ctl,
   output scf_pkg::stack_stat_type stat
);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int EW = scf_pkg::ENTRY_W;

   logic [DW-1:0] depth_ff, depth_in;
   logic [EW-1:0] tos_ff;
   logic [EW-1:0] nos_ff;
   logic [EW-1:0] mem [STACK_DEPTH];

   logic [DW-1:0] depth_m1;
   logic [DW-1:0] depth_m3;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;

   assign depth_m1 = depth_ff - DW'(1);
   assign depth_m3 = depth_ff - DW'(3);
   assign wr_addr  = depth_m1[AW-1:0];
   assign rd_addr  = depth_m3[AW-1:0];

   // Track depth
   always_comb begin
      depth_in = depth_ff;
      if (ctl.push) begin
         depth_in = depth_ff + DW'(1);
      end else if (ctl.pop) begin
         depth_in = depth_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   // Spill the old top into memory on push
   always_ff @(posedge clock) begin
      if (ctl.push && (depth_ff != '0)) begin
         mem[wr_addr] <= tos_ff;
      end
   end

   // Shift the top two entries; refill the second from memory on pop at depth >= 3
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         tos_ff <= ctl.data;
         nos_ff <= tos_ff;
      end else if (ctl.pop) begin
         tos_ff <= nos_ff;
         if (depth_ff >= DW'(3)) begin
            nos_ff <= mem[rd_addr];
         end
      end
   end

   assign stat.full  = (depth_ff == DW'(STACK_DEPTH));
   assign stat.empty = (depth_ff == '0);
   assign stat.tos   = tos_ff;

   // Checks
   a_push_pop_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctl.push && ctl.pop))
      else $error("stack push and pop in one cycle");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> (depth_ff != DW'(STACK_DEPTH)))
      else $error("push on full stack");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> (depth_ff != '0))
      else $error("pop on empty stack");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      ctl.push |=> (depth_ff == $past(depth_ff) + DW'(1)))
      else $error("depth did not grow after push");

endmodule

[src/scf_rsp_buf.sv]
// ---------------------------------------------------------------------------
// scf_rsp_buf
// Output register with a skid entry, so a request is taken while a finished
// response still waits on the receiver.
// ---------------------------------------------------------------------------
module scf_rsp_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_accept,
   input  scf_pkg::rsp_type in_data,
   output logic             in_ready,
   scf_rsp_if.source        rsp_chan
);
   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   scf_pkg::rsp_type out_data_ff, out_data_in;
   scf_pkg::rsp_type skid_data_ff, skid_data_in;
   logic             take;

   assign take     = out_valid_ff && rsp_chan.ready;
   assign in_ready = !skid_valid_ff;

   // Move responses between input, skid and output
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_accept) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.status       = out_data_ff.status;
   assign rsp_chan.dispatch     = out_data_ff.dispatch;
   assign rsp_chan.unit_slot    = out_data_ff.unit_slot;
   assign rsp_chan.cluster_now  = out_data_ff.cluster_now;
   assign rsp_chan.offset_now   = out_data_ff.offset_now;
   assign rsp_chan.cluster_load = out_data_ff.cluster_load;

endmodule

[src/script_flow_sequencer.sv]
// ---------------------------------------------------------------------------
// script_flow_sequencer
// Control-flow sequencer for a stream of 4-byte script commands.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one fetched command with the attached coprocessor's
//   ok flag and zero flag. rsp_chan returns, per request, the status, the
//   dispatch flag and slot, the current cluster and offset, and whether a
//   new cluster must be loaded. csr_wr_en/csr_wr_data write the slot
//   present mask; write it only while the block is idle.
//   Response: held in the output register, or in the skid entry on a stall.
//   Throughput: one request per cycle while the skid entry is empty; decode,
//   stack access and branch resolution are combinational into state registers.
//   Stall: an output register plus one skid entry hold responses; req_chan
//   ready drops only while the skid entry is full, and rises again as soon
//   as the receiver takes a response.
//   Reset: cluster, offset, stack depth, pending branch and zero flag clear,
//   the mask returns to 8'd27; the stack memory itself is not cleared.
// ---------------------------------------------------------------------------
module script_flow_sequencer #(
   parameter int STACK_DEPTH = scf_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   scf_req_if.sink    req_chan,
   scf_rsp_if.source  rsp_chan,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   localparam int CW = scf_pkg::CLUSTER_W;
   localparam int OW = scf_pkg::OFFSET_W;
   localparam int EW = scf_pkg::ENTRY_W;

   logic [7:0]    mask_ff;
   logic [CW-1:0] cluster_ff, cluster_in;
   logic [OW-1:0] offset_ff, offset_in;
   logic          pend_ff, pend_in;
   logic [EW-1:0] tgt_ff, tgt_in;
   logic          lz_ff, lz_in;

   logic                    accept;
   logic                    buf_ready;
   scf_pkg::stack_ctl_type  stk_ctl;
   scf_pkg::stack_stat_type stk_stat;
   scf_pkg::rsp_type        rsp_data;

   logic [OW-1:0]   cmd_off;
   logic [OW-1:0]   off_step4;
   logic [2:0]      field_hi;
   logic            resolve;
   logic            load;
   scf_pkg::status_type status;

   assign req_chan.ready = buf_ready;
   assign accept         = req_chan.valid && buf_ready;

   assign cmd_off   = {req_chan.opcode_byte[3:0], req_chan.offset_low_byte};
   assign off_step4 = offset_ff + scf_pkg::CMD_STEP;
   assign field_hi  = req_chan.opcode_byte[6:4];

   // Decode one command and work out the next sequencer state
   always_comb begin
      cluster_in  = cluster_ff;
      offset_in   = offset_ff;
      pend_in     = pend_ff;
      tgt_in      = tgt_ff;
      lz_in       = lz_ff;
      status      = scf_pkg::ST_OK;
      resolve     = 1'b0;
      load        = 1'b0;
      stk_ctl     = '0;
      rsp_data    = '0;

      if (req_chan.opcode_byte[7]) begin
         // Coprocessor command
         rsp_data.unit_slot = field_hi;
         if (!mask_ff[field_hi]) begin
            status = scf_pkg::ST_NO_UNIT;
         end else begin
            rsp_data.dispatch = 1'b1;
            lz_in = req_chan.unit_result_zero;
            if (!req_chan.unit_ok) begin
               status = scf_pkg::ST_UNIT_ERR;
            end else begin
               offset_in = offset_ff + scf_pkg::UNIT_STEP;
               resolve   = 1'b1;
            end
         end
      end else begin
         // Interpreter command
         offset_in = off_step4;
         case (field_hi)
            scf_pkg::OP_IF: begin
               if (!pend_ff) begin
                  pend_in = 1'b1;
                  tgt_in  = {req_chan.cluster_field, cmd_off};
               end
            end
            scf_pkg::OP_GOTO: begin
               if (req_chan.cluster_field != scf_pkg::KEEP_CLUSTER) begin
                  cluster_in = req_chan.cluster_field;
                  load       = 1'b1;
               end
               offset_in = cmd_off;
               resolve   = 1'b1;
            end
            scf_pkg::OP_CALL: begin
               if (stk_stat.full) begin
                  status = scf_pkg::ST_OVERFLOW;
               end else begin
                  stk_ctl.push = accept;
                  stk_ctl.data = {cluster_ff, off_step4};
                  if (req_chan.cluster_field != scf_pkg::KEEP_CLUSTER) begin
                     cluster_in = req_chan.cluster_field;
                     load       = 1'b1;
                  end
                  offset_in = cmd_off;
                  resolve   = 1'b1;
               end
            end
            scf_pkg::OP_RETURN: begin
               if (stk_stat.empty) begin
                  status = scf_pkg::ST_UNDERFLOW;
               end else begin
                  stk_ctl.pop = accept;
                  cluster_in  = stk_stat.tos[EW-1:OW];
                  offset_in   = stk_stat.tos[OW-1:0];
                  load        = 1'b1;
                  resolve     = 1'b1;
               end
            end
            default: begin
               status = scf_pkg::ST_BAD_OP;
            end
         endcase
      end

      // Drop or resolve the pending branch
      if (status != scf_pkg::ST_OK) begin
         pend_in = 1'b0;
      end else if (resolve && pend_ff) begin
         pend_in = 1'b0;
         if (lz_in) begin
            if (tgt_ff[EW-1:OW] != scf_pkg::KEEP_CLUSTER) begin
               cluster_in = tgt_ff[EW-1:OW];
               load       = 1'b1;
            end
            offset_in = tgt_ff[OW-1:0];
         end
      end

      rsp_data.status       = status;
      rsp_data.cluster_now  = cluster_in;
      rsp_data.offset_now   = offset_in;
      rsp_data.cluster_load = load;
   end

   // Hold sequencer state; advance on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_ff <= '0;
         offset_ff  <= '0;
         pend_ff    <= 1'b0;
         tgt_ff     <= '0;
         lz_ff      <= 1'b0;
      end else if (accept) begin
         cluster_ff <= cluster_in;
         offset_ff  <= offset_in;
         pend_ff    <= pend_in;
         tgt_ff     <= tgt_in;
         lz_ff      <= lz_in;
      end
   end

   // Slot present mask
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= scf_pkg::SLOT_MASK_RESET;
      end else if (csr_wr_en) begin
         mask_ff <= csr_wr_data;
      end
   end

   scf_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .ctl   (stk_ctl),
      .stat  (stk_stat)
   );

   scf_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_data   (rsp_data),
      .in_ready  (buf_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule
